>>> sv/lgs_pkg.sv
`timescale 1ns / 1ps

package lgs_pkg;

    localparam int COORD_W = 6;
    localparam int GEN_W   = 16;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_STEP  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // neighbour counts for B3/S23
    localparam logic [3:0] NB_BIRTH = 4'd3;
    localparam logic [3:0] NB_KEEP  = 4'd2;

    typedef struct packed {
        logic cap;       // capture command, clear sweep state
        logic rmw_rd;    // read cell row from current bank
        logic rmw_wr;    // write modified cell row back
        logic sw_run;    // advance the sweep by one row
        logic sw_end;    // swap banks, count generation
        logic out_load;  // load result registers
    } lgs_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       on_grid;
        logic       sweep_done;
    } lgs_sts_t;

endpackage

>>> sv/lgs_ram.sv
`timescale 1ns / 1ps

module lgs_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 128,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AddrW-1:0]  waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AddrW-1:0]  raddr,
    output logic [DATA_W-1:0] q
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            q_reg <= mem_reg[raddr];
        end
    end

    assign q = q_reg;

endmodule

>>> sv/lgs_ctrl.sv
`timescale 1ns / 1ps

module lgs_ctrl
    import lgs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  lgs_sts_t sts,
    output lgs_cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_WR    = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_END   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (sts.func == FUNC_STEP)
                begin
                    state_next = S_SWEEP;
                end
                else if (sts.func == FUNC_WRITE && sts.on_grid)
                begin
                    cmd.rmw_rd = 1'b1;
                    state_next = S_WR;
                end
                else if (sts.func == FUNC_READ && sts.on_grid)
                begin
                    cmd.rmw_rd = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_WR:
            begin
                cmd.rmw_wr = 1'b1;
                state_next = S_FIN;
            end
            S_SWEEP:
            begin
                cmd.sw_run = 1'b1;
                if (sts.sweep_done)
                begin
                    state_next = S_END;
                end
            end
            S_END:
            begin
                cmd.sw_end = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> sv/lgs_dpath.sv
`timescale 1ns / 1ps

module lgs_dpath
    import lgs_pkg::*;
#(
    parameter int GRID_SIZE = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lgs_cmd_t           cmd,
    output lgs_sts_t           sts,
    input  logic [1:0]         func,
    input  logic [COORD_W-1:0] cell_row,
    input  logic [COORD_W-1:0] cell_col,
    input  logic               cell_alive_in,
    output logic               cell_alive_out,
    output logic               grid_changed,
    output logic [GEN_W-1:0]   generation
);

    localparam int N     = GRID_SIZE;
    localparam int RW    = $clog2(N);
    localparam int AW    = RW + 1;
    localparam int MEM_D = 2 ** AW;
    localparam int KW    = $clog2(N + 2);

    // captured command
    logic [1:0]         func_reg;
    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] col_reg;
    logic               val_reg;

    // control state
    logic               bank_reg;
    logic [GEN_W-1:0]   gen_reg;
    logic               chg_reg;
    logic               acc_reg;
    logic [KW-1:0]      cnt_reg;
    logic [MEM_D-1:0]   valid_reg;
    logic               rd_ok_reg;

    // row window of the sweep
    logic [N-1:0]       prev_reg;
    logic [N-1:0]       cur_reg;

    // result
    logic               out_bit_reg;
    logic               out_chg_reg;
    logic [GEN_W-1:0]   out_gen_reg;

    logic               on_grid;
    logic [RW-1:0]      row_idx;
    logic [KW-1:0]      wrow;
    logic               sw_read;
    logic               sw_write;
    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    logic [N-1:0]       mem_wdata;
    logic [N-1:0]       mem_q;
    logic [N-1:0]       rd_row;
    logic [N-1:0]       col_hot;
    logic [N-1:0]       rmw_row;
    logic [N-1:0]       next_row;
    logic [N+1:0]       up_x;
    logic [N+1:0]       mid_x;
    logic [N+1:0]       dn_x;
    logic               read_bit;

    assign on_grid = (32'(row_reg) < 32'(N)) && (32'(col_reg) < 32'(N));
    assign row_idx = RW'(row_reg);
    assign wrow    = cnt_reg - KW'(2);

    assign sw_read  = cmd.sw_run && (cnt_reg < KW'(N));
    assign sw_write = cmd.sw_run && (cnt_reg >= KW'(2));

    assign mem_re    = cmd.rmw_rd || sw_read;
    assign mem_raddr = cmd.sw_run ? {bank_reg, cnt_reg[RW-1:0]} : {bank_reg, row_idx};
    assign mem_we    = cmd.rmw_wr || sw_write;
    assign mem_waddr = cmd.rmw_wr ? {bank_reg, row_idx} : {~bank_reg, wrow[RW-1:0]};
    assign mem_wdata = cmd.rmw_wr ? rmw_row : next_row;

    assign rd_row = rd_ok_reg ? mem_q : '0;

    always_comb
    begin
        for (int c = 0; c < N; c++)
        begin
            col_hot[c] = (32'(col_reg) == 32'(c));
            rmw_row[c] = col_hot[c] ? val_reg : rd_row[c];
        end
    end

    assign read_bit = |(rd_row & col_hot);

    // next generation of the middle row, one cell per column
    assign up_x  = {1'b0, prev_reg, 1'b0};
    assign mid_x = {1'b0, cur_reg, 1'b0};
    assign dn_x  = {1'b0, rd_row, 1'b0};

    for (genvar c = 0; c < N; c++)
    begin : g_cell
        logic [3:0] nb;
        assign nb = 4'(up_x[c]) + 4'(up_x[c+1]) + 4'(up_x[c+2])
                  + 4'(mid_x[c]) + 4'(mid_x[c+2])
                  + 4'(dn_x[c]) + 4'(dn_x[c+1]) + 4'(dn_x[c+2]);
        assign next_row[c] = (nb == NB_BIRTH) || (mid_x[c+1] && (nb == NB_KEEP));
    end

    lgs_ram #(
        .DATA_W (N),
        .DEPTH  (MEM_D)
    ) u_grid (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .q     (mem_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg  <= 1'b0;
            gen_reg   <= '0;
            chg_reg   <= 1'b0;
            acc_reg   <= 1'b0;
            cnt_reg   <= '0;
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cap)
            begin
                cnt_reg <= '0;
                acc_reg <= 1'b0;
            end
            if (cmd.sw_run)
            begin
                cnt_reg <= cnt_reg + KW'(1);
                if (sw_write)
                begin
                    acc_reg <= acc_reg | (|(next_row ^ cur_reg));
                end
            end
            if (cmd.rmw_rd || cmd.sw_run)
            begin
                rd_ok_reg <= (!cmd.sw_run || sw_read) && valid_reg[mem_raddr];
            end
            if (mem_we)
            begin
                valid_reg[mem_waddr] <= 1'b1;
            end
            if (cmd.sw_end)
            begin
                bank_reg <= ~bank_reg;
                gen_reg  <= gen_reg + GEN_W'(1);
                chg_reg  <= acc_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            func_reg <= func;
            row_reg  <= cell_row;
            col_reg  <= cell_col;
            val_reg  <= cell_alive_in;
            prev_reg <= '0;
            cur_reg  <= '0;
        end
        else if (cmd.sw_run && (cnt_reg != '0))
        begin
            prev_reg <= cur_reg;
            cur_reg  <= rd_row;
        end
        if (cmd.out_load)
        begin
            out_bit_reg <= (func_reg == FUNC_READ) && on_grid && read_bit;
            out_chg_reg <= chg_reg;
            out_gen_reg <= gen_reg;
        end
    end

    assign sts.func       = func_reg;
    assign sts.on_grid    = on_grid;
    assign sts.sweep_done = (cnt_reg == KW'(N + 1));

    assign cell_alive_out = out_bit_reg;
    assign grid_changed   = out_chg_reg;
    assign generation     = out_gen_reg;

endmodule

>>> sv/life_grid_generation_step.sv
`timescale 1ns / 1ps

// Game of Life (B3/S23) on a GRID_SIZE x GRID_SIZE grid with dead borders, held as
// two banks of row words in one RAM with valid bits per row (reset clears the grid at
// once, no clearing pass). One command is taken at a time and gives one result beat.
// A write is a row read-modify-write, and a generation step sweeps the current
// bank one row per cycle through the RAM read port while the next rows are written
// to the other bank. The next command may be taken while a result beat still waits.
module life_grid_generation_step
    import lgs_pkg::*;
#(
    parameter int GRID_SIZE = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic [COORD_W-1:0] cell_row,
    input  logic [COORD_W-1:0] cell_col,
    input  logic               cell_alive_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               cell_alive_out,
    output logic               grid_changed,
    output logic [GEN_W-1:0]   generation
);

    lgs_cmd_t cmd;
    lgs_sts_t sts;

    lgs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lgs_dpath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .func           (func),
        .cell_row       (cell_row),
        .cell_col       (cell_col),
        .cell_alive_in  (cell_alive_in),
        .cell_alive_out (cell_alive_out),
        .grid_changed   (grid_changed),
        .generation     (generation)
    );

endmodule

>>> sv/lgs_checker.sv
`timescale 1ns / 1ps

module lgs_checker
    import lgs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               cell_alive_out,
    input  logic               grid_changed,
    input  logic [GEN_W-1:0]   generation
);

    logic [GEN_W-1:0] last_gen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_gen_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            last_gen_reg <= generation;
        end
    end

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(generation)
            && $stable(grid_changed) && $stable(cell_alive_out))
        else $error("result beat changed while stalled");

    // each result advances the generation by at most one
    a_gen_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |->
            (generation == last_gen_reg) || (generation == last_gen_reg + GEN_W'(1)))
        else $error("generation skipped");

    // one command in work at a time
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("command taken while busy");

    // no result beat right after a command is taken unless one was already waiting
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result beat too early");

endmodule

bind life_grid_generation_step lgs_checker u_lgs_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

    import lgs_pkg::*;

    localparam int GS = 64;
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int ITEM_TARGET = 1900;

    typedef struct {
        logic [1:0]         func;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               alive;
        bit                 drain;
    } life_cmd_t;

    typedef struct {
        logic             alive_bit;
        logic             changed;
        logic [GEN_W-1:0] gen;
    } life_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         func = FUNC_WRITE;
    logic [COORD_W-1:0] cell_row = '0;
    logic [COORD_W-1:0] cell_col = '0;
    logic               cell_alive_in = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               cell_alive_out;
    logic               grid_changed;
    logic [GEN_W-1:0]   generation;

    life_grid_generation_step #(.GRID_SIZE(GS)) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .cell_row       (cell_row),
        .cell_col       (cell_col),
        .cell_alive_in  (cell_alive_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cell_alive_out (cell_alive_out),
        .grid_changed   (grid_changed),
        .generation     (generation)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    logic [GS-1:0]    life_now [GS];
    logic [GEN_W-1:0] gen_count = '0;
    logic             last_chg = 1'b0;

    life_cmd_t    pending [$];
    life_result_t result_q [$];

    int n_total = 0;
    int n_sent = 0;
    int n_rcv = 0;
    int n_err = 0;
    int n_wr = 0;
    int n_rd = 0;
    int n_step = 0;
    int n_none = 0;
    int n_live_reads = 0;
    int n_chg_steps = 0;

    initial
    begin
        for (int r = 0; r < GS; r++)
            life_now[r] = '0;
    end

    task automatic report_miss(input string msg);
        $display("ERROR @%0t beat %0d: %s", $time, n_rcv, msg);
        n_err++;
    endtask

    task automatic step_generation();
        logic [GS-1:0] nxt [GS];
        logic [GS-1:0] up;
        logic [GS-1:0] dn;
        logic [GS-1:0] mid;
        int  n;
        bit  diff;
        diff = 0;
        for (int r = 0; r < GS; r++)
        begin
            up  = (r > 0) ? life_now[r-1] : '0;
            dn  = (r < GS - 1) ? life_now[r+1] : '0;
            mid = life_now[r];
            for (int c = 0; c < GS; c++)
            begin
                n = 0;
                for (int dc = -1; dc <= 1; dc++)
                begin
                    if (c + dc >= 0 && c + dc < GS)
                    begin
                        n += up[c+dc] + dn[c+dc];
                        if (dc != 0)
                            n += mid[c+dc];
                    end
                end
                nxt[r][c] = (n == NB_BIRTH || (mid[c] && n == NB_KEEP));
                if (nxt[r][c] != mid[c])
                    diff = 1;
            end
        end
        for (int r = 0; r < GS; r++)
            life_now[r] = nxt[r];
        last_chg = diff;
        gen_count = gen_count + 1'b1;
        n_step++;
        if (diff)
            n_chg_steps++;
    endtask

    task automatic predict_result(input logic [1:0] f, input logic [COORD_W-1:0] r,
                                  input logic [COORD_W-1:0] c, input logic v);
        life_result_t res;
        bit on_grid;
        on_grid = (r < GS) && (c < GS);
        res.alive_bit = 1'b0;
        case (f)
            FUNC_WRITE:
            begin
                if (on_grid)
                    life_now[r][c] = v;
                n_wr++;
            end
            FUNC_STEP:
                step_generation();
            FUNC_READ:
            begin
                if (on_grid)
                    res.alive_bit = life_now[r][c];
                n_rd++;
                if (res.alive_bit)
                    n_live_reads++;
            end
            default:
                n_none++;
        endcase
        res.changed = last_chg;
        res.gen = gen_count;
        result_q.push_back(res);
    endtask

    function automatic int draw_wait(input int n);
        if ((n / 64) % 3 == 2)
            return 0;
        return $urandom_range(0, 8);
    endfunction

    // driver
    bit tx_busy = 0;
    int tx_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        life_cmd_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_busy = 0;
            tx_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_result(func, cell_row, cell_col, cell_alive_in);
                n_sent++;
                tx_busy = 0;
            end
            if (!tx_busy)
            begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (pending.size() > 0)
                begin
                    if (pending[0].drain)
                    begin
                        if (result_q.size() == 0)
                            void'(pending.pop_front());
                    end
                    else
                    begin
                        nxt = pending.pop_front();
                        func <= nxt.func;
                        cell_row <= nxt.row;
                        cell_col <= nxt.col;
                        cell_alive_in <= nxt.alive;
                        tx_busy = 1;
                        tx_gap = draw_wait(n_sent);
                    end
                end
            end
            in_valid <= tx_busy;
        end
    end

    // monitor
    int rx_wait = 0;
    int rx_hold = 0;

    always @(posedge clk or negedge rst_n)
    begin
        life_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait = 0;
            rx_hold = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                    report_miss("result beat with nothing outstanding");
                else
                begin
                    want = result_q.pop_front();
                    if (cell_alive_out !== want.alive_bit)
                        report_miss($sformatf("cell_alive_out %b, want %b",
                                              cell_alive_out, want.alive_bit));
                    if (grid_changed !== want.changed)
                        report_miss($sformatf("grid_changed %b, want %b",
                                              grid_changed, want.changed));
                    if (generation !== want.gen)
                        report_miss($sformatf("generation %0d, want %0d",
                                              generation, want.gen));
                end
                n_rcv++;
                rx_wait = draw_wait(n_rcv);
                if (n_rcv == 300)
                    rx_hold = 600;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_ready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic queue_cmd(input logic [1:0] f, input int r, input int c, input logic v);
        life_cmd_t cmd;
        cmd.func = f;
        cmd.row = r[COORD_W-1:0];
        cmd.col = c[COORD_W-1:0];
        cmd.alive = v;
        cmd.drain = 0;
        pending.push_back(cmd);
        n_total++;
    endtask

    function automatic int clamp_coord(input int v);
        if (v < 0)
            return 0;
        if (v > GS - 1)
            return GS - 1;
        return v;
    endfunction

    function automatic int pick_origin(input int span);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return GS - span;
            default: return $urandom_range(0, GS - span);
        endcase
    endfunction

    // seed a small patch, run a few generations and probe around it
    task automatic queue_episode();
        int r0;
        int c0;
        int h;
        int w;
        int nw;
        int ns;
        int nr;
        h = $urandom_range(3, 8);
        w = $urandom_range(3, 8);
        r0 = pick_origin(h);
        c0 = pick_origin(w);
        if ($urandom_range(0, 4) == 0)
        begin
            for (int i = 0; i < h; i++)
                for (int j = 0; j < w; j++)
                    queue_cmd(FUNC_WRITE, r0 + i, c0 + j, 1'b0);
        end
        nw = $urandom_range(6, h * w);
        for (int i = 0; i < nw; i++)
            queue_cmd(FUNC_WRITE, r0 + $urandom_range(0, h - 1), c0 + $urandom_range(0, w - 1),
                      $urandom_range(0, 3) != 0);
        ns = $urandom_range(1, 4);
        for (int s = 0; s < ns; s++)
        begin
            queue_cmd(FUNC_STEP, $urandom_range(0, GS - 1), $urandom_range(0, GS - 1),
                      1'($urandom_range(0, 1)));
            nr = $urandom_range(2, 6);
            for (int i = 0; i < nr; i++)
            begin
                if ($urandom_range(0, 5) == 0)
                    queue_cmd(FUNC_READ, $urandom_range(0, GS - 1), $urandom_range(0, GS - 1),
                              1'($urandom_range(0, 1)));
                else
                    queue_cmd(FUNC_READ, clamp_coord(r0 - 1 + $urandom_range(0, h + 1)),
                              clamp_coord(c0 - 1 + $urandom_range(0, w + 1)),
                              1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 7) == 0)
                queue_cmd(FUNC_NONE, $urandom_range(0, GS - 1), $urandom_range(0, GS - 1),
                          1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 2) == 0)
            queue_cmd(2'($urandom_range(0, 3)), $urandom_range(0, GS - 1),
                      $urandom_range(0, GS - 1), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        life_cmd_t pause;
        bit paused;
        pause.func = FUNC_NONE;
        pause.row = '0;
        pause.col = '0;
        pause.alive = 1'b0;
        pause.drain = 1;
        paused = 0;

        // corners
        queue_cmd(FUNC_WRITE, 0, 0, 1'b1);
        queue_cmd(FUNC_WRITE, 0, GS - 1, 1'b1);
        queue_cmd(FUNC_WRITE, GS - 1, 0, 1'b1);
        queue_cmd(FUNC_WRITE, GS - 1, GS - 1, 1'b1);
        queue_cmd(FUNC_READ, 0, 0, 1'b0);
        queue_cmd(FUNC_READ, 0, GS - 1, 1'b1);
        queue_cmd(FUNC_READ, GS - 1, 0, 1'b0);
        queue_cmd(FUNC_READ, GS - 1, GS - 1, 1'b1);
        queue_cmd(FUNC_READ, 1, 1, 1'b0);
        queue_cmd(FUNC_NONE, GS - 1, GS - 1, 1'b1);
        // lone cells die
        queue_cmd(FUNC_STEP, 0, 0, 1'b0);
        queue_cmd(FUNC_READ, 0, 0, 1'b0);
        // empty grid, nothing changes
        queue_cmd(FUNC_STEP, GS - 1, GS - 1, 1'b1);
        // blinker on the top edge
        queue_cmd(FUNC_WRITE, 0, 30, 1'b1);
        queue_cmd(FUNC_WRITE, 0, 31, 1'b1);
        queue_cmd(FUNC_WRITE, 0, 32, 1'b1);
        queue_cmd(FUNC_STEP, 5, 5, 1'b0);
        queue_cmd(FUNC_READ, 1, 31, 1'b0);
        queue_cmd(FUNC_READ, 0, 30, 1'b0);
        queue_cmd(FUNC_READ, 0, 31, 1'b1);
        queue_cmd(FUNC_NONE, 0, 0, 1'b0);
        // kill a live cell by writing zero
        queue_cmd(FUNC_WRITE, 0, 31, 1'b0);
        queue_cmd(FUNC_READ, 0, 31, 1'b0);
        queue_cmd(FUNC_STEP, 0, 0, 1'b1);

        while (n_total < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_cmd(2'($urandom_range(0, 3)), $urandom_range(0, GS - 1),
                          $urandom_range(0, GS - 1), 1'($urandom_range(0, 1)));
            else
                queue_episode();
            if (!paused && n_total >= ITEM_TARGET / 2)
            begin
                pending.push_back(pause);
                paused = 1;
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (n_sent < n_total || result_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (result_q.size() != 0)
            report_miss($sformatf("%0d results never arrived", result_q.size()));

        $display("Covered %0d commands: %0d writes, %0d reads (%0d live), %0d unused codes",
                 n_sent, n_wr, n_rd, n_live_reads, n_none);
        $display("and %0d generations (%0d with changes), final generation %0d",
                 n_step, n_chg_steps, gen_count);
        if (n_err == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("TIMEOUT after %0d of %0d commands, %0d results", n_sent, n_total, n_rcv);
        $display("Mismatches found");
        $finish;
    end

endmodule
